// File: rtl/hrlp_pkg.sv
package hrlp_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;
  localparam int OFS_W = 10;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_Z     = 8'd90;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_E     = 8'd69;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_O     = 8'd79;
  localparam logic [7:0] CH_S     = 8'd83;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_METHOD  = 2'd1;
  localparam logic [1:0] ST_BAD_REQUEST = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  localparam logic [1:0] MK_UNKNOWN = 2'd0;
  localparam logic [1:0] MK_GET     = 2'd1;
  localparam logic [1:0] MK_POST    = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       method_kind;
    logic [OFS_W-1:0] method_end_offset;
    logic [OFS_W-1:0] uri_start_offset;
    logic [OFS_W-1:0] uri_end_offset;
    logic [OFS_W-1:0] line_end_offset;
  } out_item_t;

endpackage

// File: rtl/http_request_line_parser.sv
// HTTP request line parser.
// Bytes of a request buffer enter on the in_ channel (valid/stall), one item
// per byte, with first_byte marking the start of a buffer and last_byte its
// end. The out_ channel carries at most one result item per buffer: a status
// code, the method class and the offsets of the method end, URI start, URI
// end and line end, modulo 1024.
// An accepted byte is held in an input register. When it is processed,
// the parse state is updated and its result, if any, is written to the
// output register, which drives out_valid.
// One byte is accepted every cycle while in_stall is low, set by the single
// state update between the input and output registers.
// When the receiver stalls a waiting result, a byte in the input register
// waits until the output register is free; in_stall is raised while a byte
// sits in the input register behind a stalled result.
// After reset the parser is in its start phase, as if a buffer had begun,
// and both channels are empty.
module http_request_line_parser #(
  parameter int BUFFER_BYTES = hrlp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrlp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrlp_pkg::out_item_t out_data
);

  logic                s1_valid_r;
  hrlp_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  hrlp_pkg::out_item_t out_item_r;
  logic                adv;
  logic                proc;
  logic                res_valid;
  hrlp_pkg::out_item_t res;

  assign adv      = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  hrlp_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (proc),
    .item     (s1_item_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= proc && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (proc && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
    proc && res_valid |=> out_valid_r)
    else $error("parser result was not registered");

endmodule

// File: rtl/hrlp_core.sv
module hrlp_core #(
  parameter int BUFFER_BYTES = hrlp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  hrlp_pkg::in_item_t  item,
  output logic                res_valid,
  output hrlp_pkg::out_item_t res
);

  localparam int POS_W = $clog2(BUFFER_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_METHOD,
    PH_SPACES,
    PH_URI,
    PH_VERSION,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] mstart;
    logic             get_m;
    logic             post_m;
    logic [1:0]       found;
    logic [POS_W-1:0] mend;
    logic [POS_W-1:0] ustart;
    logic [POS_W-1:0] uend;
    logic [POS_W-1:0] lend;
    logic             halted;
  } state_t;

  localparam state_t ST_CLEAR = '{
    phase:  PH_START,
    pos:    '0,
    mstart: '0,
    get_m:  1'b1,
    post_m: 1'b1,
    found:  hrlp_pkg::MK_UNKNOWN,
    mend:   '0,
    ustart: '0,
    uend:   '0,
    lend:   '0,
    halted: 1'b0
  };

  state_t           st_r;
  state_t           st_nxt;
  state_t           cur;
  logic             last;
  logic             stop;
  logic [1:0]       status;
  logic [POS_W-1:0] k;
  logic [7:0]       ch;

  assign ch = item.byte_value;
  assign k  = cur.pos - cur.mstart;

  always_comb begin
    cur       = item.first_byte ? ST_CLEAR : st_r;
    st_nxt    = cur;
    res_valid = 1'b0;
    status    = hrlp_pkg::ST_OK;
    stop      = 1'b0;
    last      = item.last_byte || (cur.pos >= LAST_POS);
    if (!cur.halted) begin
      unique case (cur.phase)
        PH_START: begin
          if (ch != hrlp_pkg::CH_CR && ch != hrlp_pkg::CH_LF) begin
            if (ch < hrlp_pkg::CH_A || ch > hrlp_pkg::CH_Z) begin
              stop   = 1'b1;
              status = hrlp_pkg::ST_BAD_METHOD;
            end else begin
              st_nxt.mstart = cur.pos;
              st_nxt.get_m  = (ch == hrlp_pkg::CH_G);
              st_nxt.post_m = (ch == hrlp_pkg::CH_P);
              st_nxt.phase  = PH_METHOD;
            end
          end
        end
        PH_METHOD: begin
          if (ch == hrlp_pkg::CH_SP) begin
            st_nxt.mend = cur.pos - POS_W'(1);
            if (k == POS_W'(3) && cur.get_m) begin
              st_nxt.found = hrlp_pkg::MK_GET;
            end else if (k == POS_W'(4) && cur.post_m) begin
              st_nxt.found = hrlp_pkg::MK_POST;
            end else begin
              st_nxt.found = hrlp_pkg::MK_UNKNOWN;
            end
            st_nxt.phase = PH_SPACES;
          end else if (k == POS_W'(1)) begin
            st_nxt.get_m  = cur.get_m && (ch == hrlp_pkg::CH_E);
            st_nxt.post_m = cur.post_m && (ch == hrlp_pkg::CH_O);
          end else if (k == POS_W'(2)) begin
            st_nxt.get_m  = cur.get_m && (ch == hrlp_pkg::CH_T);
            st_nxt.post_m = cur.post_m && (ch == hrlp_pkg::CH_S);
          end else if (k == POS_W'(3)) begin
            st_nxt.get_m  = 1'b0;
            st_nxt.post_m = cur.post_m && (ch == hrlp_pkg::CH_T);
          end else begin
            st_nxt.get_m  = 1'b0;
            st_nxt.post_m = 1'b0;
          end
        end
        PH_SPACES: begin
          if (ch == hrlp_pkg::CH_SLASH) begin
            st_nxt.ustart = cur.pos;
            st_nxt.phase  = PH_URI;
          end else if (ch != hrlp_pkg::CH_SP) begin
            stop   = 1'b1;
            status = hrlp_pkg::ST_BAD_REQUEST;
          end
        end
        PH_URI: begin
          if (ch == hrlp_pkg::CH_SP) begin
            st_nxt.uend  = cur.pos;
            st_nxt.phase = PH_VERSION;
          end else if (ch == hrlp_pkg::CH_LF) begin
            st_nxt.uend  = cur.pos - POS_W'(1);
            st_nxt.phase = PH_DONE;
          end
        end
        PH_VERSION: begin
          if (ch == hrlp_pkg::CH_LF) begin
            st_nxt.lend  = cur.pos - POS_W'(1);
            st_nxt.phase = PH_DONE;
          end
        end
        default: begin
          // The byte after the closing LF reports completion.
          stop   = 1'b1;
          status = hrlp_pkg::ST_OK;
        end
      endcase
      if (stop) begin
        res_valid = 1'b1;
      end else if (last) begin
        res_valid = 1'b1;
        status    = hrlp_pkg::ST_TRUNCATED;
      end else begin
        st_nxt.pos = cur.pos + POS_W'(1);
      end
      if (res_valid) begin
        st_nxt.halted = 1'b1;
      end
    end
  end

  assign res.status            = status;
  assign res.method_kind       = st_nxt.found;
  assign res.method_end_offset = hrlp_pkg::OFS_W'(st_nxt.mend);
  assign res.uri_start_offset  = hrlp_pkg::OFS_W'(st_nxt.ustart);
  assign res.uri_end_offset    = hrlp_pkg::OFS_W'(st_nxt.uend);
  assign res.line_end_offset   = hrlp_pkg::OFS_W'(st_nxt.lend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  a_quiet_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    en && st_r.halted && !item.first_byte |-> !res_valid)
    else $error("result produced while halted");

  a_halt_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    en && res_valid |=> st_r.halted)
    else $error("parser did not halt after a result");

endmodule
